// ===== hdl/cta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types and constants of the command tag allocator.
// ----------------------------------------------------------------------------
package cta_pkg;

    // request codes
    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_START    = 2'd2,
        REQ_NONE     = 2'd3
    } req_type_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_OWNER,
        ST_DESC
    } state_t;

    // field widths
    localparam int CNT_W    = 9;
    localparam int ERR_W    = 15;
    localparam int QS_W     = 9;
    localparam int TAG_W    = 8;
    localparam int DESC_W   = 4;
    localparam int REM_W    = 8;

    localparam logic [CNT_W-1:0] CNT_MAX   = 9'h1FF;
    localparam logic [REM_W-1:0] REM_MAX   = 8'hFF;
    localparam logic [QS_W-1:0]  QS_MIN    = 9'd2;
    localparam logic [QS_W-1:0]  QS_RESET  = 9'd256;

    // register index, taken from paddr[2]
    localparam logic REG_QUEUE_SIZE = 1'b0;

    // one descriptor table entry
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ERR_W-1:0] err;
    } desc_entry_t;

    // descriptor table write command
    typedef struct packed {
        logic        en;
        desc_entry_t entry;
    } desc_wr_t;

endpackage

// ===== hdl/command_tag_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_tag_allocator_core
// Rotating bitmap allocator of command tags with per-descriptor accounting.
// ----------------------------------------------------------------------------
// Allocate: bitmap tree scan (ST_SCAN registers the group summary, ST_PICK
//   picks), then read-modify-write of the descriptor table in ST_DESC; refused
//   in ST_PICK when the scan finds no free tag, in ST_IDLE on the used count.
// Complete: owner memory read, then descriptor table read-modify-write;
//   an unknown tag, start and unused requests are answered from ST_IDLE.
// One request at a time: busy is high until the result strobe; the receiver
//   cannot stall. Reset clears bitmap, counts, pointer and descriptor valid bits
//   at once; no clearing pass.
// ----------------------------------------------------------------------------
module command_tag_allocator_core #(
    parameter int MAX_TAGS  = 256,
    parameter int NUM_DESCS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request side
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [cta_pkg::DESC_W-1:0]   desc_id,
    input  logic [cta_pkg::TAG_W-1:0]    tag_in,
    input  logic [cta_pkg::ERR_W-1:0]    status_in,
    // result side
    output logic                         res_valid,
    output logic [cta_pkg::TAG_W-1:0]    tag_out,
    output logic                         full_res,
    output logic                         bad_tag,
    output logic [cta_pkg::DESC_W-1:0]   owner_desc,
    output logic [cta_pkg::REM_W-1:0]    desc_remaining,
    output logic [cta_pkg::ERR_W-1:0]    desc_status,
    output logic                         desc_done,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cta_pkg::*;

    localparam int TAG_DEPTH = (MAX_TAGS < 256) ? MAX_TAGS : 256;
    localparam int TW        = $clog2(TAG_DEPTH);
    localparam int DW        = $clog2(NUM_DESCS);

    // descriptor id reduced into the table range by repeated subtraction
    function automatic logic [DW-1:0] desc_wrap(input logic [DESC_W-1:0] id);
        logic [DESC_W-1:0] v;
        v = id;
        for (int i = 0; i < 8; i++)
        begin
            if (int'(v) >= NUM_DESCS)
            begin
                v = v - DESC_W'(NUM_DESCS);
            end
        end
        return DW'(v);
    endfunction

    state_t               state_reg, state_next;
    logic [QS_W-1:0]      queue_size_reg;
    logic [QS_W-1:0]      qs;
    logic [TAG_DEPTH-1:0] tag_used_reg;
    logic [TW-1:0]        search_ptr_reg, search_ptr_next;
    logic [QS_W-1:0]      used_count_reg, used_count_next;
    req_type_t            op_reg, op_next;
    logic [DW-1:0]        desc_idx_reg, desc_idx_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [ERR_W-1:0]     status_reg, status_next;

    logic [DW-1:0]        owner_mem [TAG_DEPTH];
    logic [DW-1:0]        owner_rd_reg;
    logic                 owner_wr_en;

    logic                 res_valid_reg, res_valid_next;
    logic [TAG_W-1:0]     tag_out_reg, tag_out_next;
    logic                 full_res_reg, full_res_next;
    logic                 bad_tag_reg, bad_tag_next;
    logic [DESC_W-1:0]    owner_desc_reg, owner_desc_next;
    logic [REM_W-1:0]     desc_rem_reg, desc_rem_next;
    logic [ERR_W-1:0]     desc_status_reg, desc_status_next;
    logic                 desc_done_reg, desc_done_next;

    logic                 accept;
    req_type_t            req;
    logic [DW-1:0]        d_in;
    logic                 tag_ok;
    logic                 q_full;
    logic                 used_set, used_clr;
    logic                 scan_load, scan_found;
    logic [TW-1:0]        scan_pick;
    logic [DW-1:0]        desc_rd_addr, desc_wr_addr;
    desc_wr_t             desc_wr;
    desc_entry_t          desc_rd_entry;
    logic [CNT_W-1:0]     cnt_upd;
    logic [ERR_W-1:0]     err_upd;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUEUE_SIZE) ? {{(32 - QS_W){1'b0}}, queue_size_reg}
                                                 : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_size_reg <= QS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_SIZE))
        begin
            queue_size_reg <= pwdata[QS_W-1:0];
        end
    end

    // effective queue size
    always_comb
    begin
        qs = queue_size_reg;
        if (qs < QS_MIN)
        begin
            qs = QS_MIN;
        end
        if (qs > QS_W'(TAG_DEPTH))
        begin
            qs = QS_W'(TAG_DEPTH);
        end
    end

    // request decode
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign req    = req_type_t'(req_type);
    assign d_in   = desc_wrap(desc_id);
    assign tag_ok = ({1'b0, tag_in} < QS_W'(TAG_DEPTH)) && tag_used_reg[tag_in[TW-1:0]];
    assign q_full = ((QS_W + 1)'(used_count_reg) + (QS_W + 1)'(1)) >= (QS_W + 1)'(qs);

    // descriptor update for the pending allocate or complete
    always_comb
    begin
        cnt_upd = desc_rd_entry.count;
        err_upd = desc_rd_entry.err;
        if (op_reg == REQ_ALLOC)
        begin
            if (desc_rd_entry.count != CNT_MAX)
            begin
                cnt_upd = desc_rd_entry.count + CNT_W'(1);
            end
        end
        else
        begin
            if (desc_rd_entry.count != '0)
            begin
                cnt_upd = desc_rd_entry.count - CNT_W'(1);
            end
            if (status_reg != '0)
            begin
                err_upd = status_reg;
            end
        end
    end

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next       = state_reg;
        search_ptr_next  = search_ptr_reg;
        used_count_next  = used_count_reg;
        op_next          = op_reg;
        desc_idx_next    = desc_idx_reg;
        tag_next         = tag_reg;
        status_next      = status_reg;
        used_set         = 1'b0;
        used_clr         = 1'b0;
        scan_load        = 1'b0;
        owner_wr_en      = 1'b0;
        desc_rd_addr     = desc_idx_reg;
        desc_wr_addr     = desc_idx_reg;
        desc_wr          = '0;
        res_valid_next   = 1'b0;
        tag_out_next     = '0;
        full_res_next    = 1'b0;
        bad_tag_next     = 1'b0;
        owner_desc_next  = '0;
        desc_rem_next    = '0;
        desc_status_next = '0;
        desc_done_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = req;
                    tag_next      = tag_in;
                    status_next   = status_in;
                    desc_idx_next = d_in;
                    case (req)
                        REQ_ALLOC:
                        begin
                            if (q_full)
                            begin
                                res_valid_next = 1'b1;
                                full_res_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_COMPLETE:
                        begin
                            if (!tag_ok)
                            begin
                                res_valid_next = 1'b1;
                                bad_tag_next   = 1'b1;
                                tag_out_next   = tag_in;
                            end
                            else
                            begin
                                // free the tag now, owner read is under way
                                used_clr        = 1'b1;
                                search_ptr_next = tag_in[TW-1:0];
                                if (used_count_reg != '0)
                                begin
                                    used_count_next = used_count_reg - QS_W'(1);
                                end
                                state_next = ST_OWNER;
                            end
                        end
                        REQ_START:
                        begin
                            desc_wr.en      = 1'b1;
                            desc_wr_addr    = d_in;
                            res_valid_next  = 1'b1;
                            owner_desc_next = DESC_W'(d_in);
                            desc_done_next  = 1'b1;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_load  = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (!scan_found)
                begin
                    res_valid_next = 1'b1;
                    full_res_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    used_set        = 1'b1;
                    owner_wr_en     = 1'b1;
                    used_count_next = used_count_reg + QS_W'(1);
                    tag_next        = TAG_W'(scan_pick);
                    if ((QS_W'(scan_pick) + QS_W'(1)) >= qs)
                    begin
                        search_ptr_next = '0;
                    end
                    else
                    begin
                        search_ptr_next = scan_pick + TW'(1);
                    end
                    state_next = ST_DESC;
                end
            end
            ST_OWNER:
            begin
                desc_rd_addr  = owner_rd_reg;
                desc_idx_next = owner_rd_reg;
                state_next    = ST_DESC;
            end
            ST_DESC:
            begin
                desc_wr.en          = 1'b1;
                desc_wr.entry.count = cnt_upd;
                desc_wr.entry.err   = err_upd;
                res_valid_next      = 1'b1;
                tag_out_next        = tag_reg;
                owner_desc_next     = DESC_W'(desc_idx_reg);
                desc_rem_next       = (cnt_upd > CNT_W'(REM_MAX)) ? REM_MAX
                                                                  : cnt_upd[REM_W-1:0];
                desc_status_next    = err_upd;
                desc_done_next      = (cnt_upd == '0);
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            search_ptr_reg <= '0;
            used_count_reg <= '0;
            tag_used_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            search_ptr_reg <= search_ptr_next;
            used_count_reg <= used_count_next;
            res_valid_reg  <= res_valid_next;
            if (used_set)
            begin
                tag_used_reg[scan_pick] <= 1'b1;
            end
            if (used_clr)
            begin
                tag_used_reg[tag_in[TW-1:0]] <= 1'b0;
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        desc_idx_reg    <= desc_idx_next;
        tag_reg         <= tag_next;
        status_reg      <= status_next;
        tag_out_reg     <= tag_out_next;
        full_res_reg    <= full_res_next;
        bad_tag_reg     <= bad_tag_next;
        owner_desc_reg  <= owner_desc_next;
        desc_rem_reg    <= desc_rem_next;
        desc_status_reg <= desc_status_next;
        desc_done_reg   <= desc_done_next;
    end

    // tag owner memory
    always_ff @(posedge clk)
    begin
        if (owner_wr_en)
        begin
            owner_mem[scan_pick] <= desc_idx_reg;
        end
        owner_rd_reg <= owner_mem[tag_in[TW-1:0]];
    end

    // free tag search
    cta_scan #(
        .TAG_DEPTH (TAG_DEPTH),
        .TW        (TW)
    ) u_scan (
        .clk   (clk),
        .load  (scan_load),
        .used  (tag_used_reg),
        .ptr   (search_ptr_reg),
        .qs    (qs),
        .found (scan_found),
        .pick  (scan_pick)
    );

    // descriptor count and status table
    cta_desc_table #(
        .NUM_DESCS (NUM_DESCS),
        .DW        (DW)
    ) u_desc_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (desc_rd_addr),
        .rd_entry (desc_rd_entry),
        .wr       (desc_wr),
        .wr_addr  (desc_wr_addr)
    );

    // result ports
    assign res_valid      = res_valid_reg;
    assign tag_out        = tag_out_reg;
    assign full_res       = full_res_reg;
    assign bad_tag        = bad_tag_reg;
    assign owner_desc     = owner_desc_reg;
    assign desc_remaining = desc_rem_reg;
    assign desc_status    = desc_status_reg;
    assign desc_done      = desc_done_reg;

endmodule

// ===== hdl/cta_desc_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_desc_table
// Per-descriptor count and sticky status, registered synchronous read.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module cta_desc_table #(
    parameter int NUM_DESCS = 16,
    parameter int DW        = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DW-1:0]        rd_addr,
    output cta_pkg::desc_entry_t rd_entry,
    input  cta_pkg::desc_wr_t    wr,
    input  logic [DW-1:0]        wr_addr
);
    import cta_pkg::*;

    desc_entry_t          mem [NUM_DESCS];
    logic [NUM_DESCS-1:0] valid_reg;
    desc_entry_t          rd_data_reg;
    logic                 rd_valid_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // valid bits, cleared together at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // unwritten entries read as zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/cta_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_scan
// Rotating first-free search over the tag bitmap as a two-level tree.
// Level one (registered on load) finds the first free tag of each group,
// once at or above the start point and once over the whole queue; level two picks.
// ----------------------------------------------------------------------------
module cta_scan #(
    parameter int TAG_DEPTH = 256,
    parameter int TW        = 8
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [TAG_DEPTH-1:0]         used,
    input  logic [TW-1:0]                ptr,
    input  logic [cta_pkg::QS_W-1:0]     qs,
    output logic                         found,
    output logic [TW-1:0]                pick
);
    import cta_pkg::*;

    localparam int GW = 16;
    localparam int NG = (TAG_DEPTH + GW - 1) / GW;

    logic [TW-1:0] start_idx;
    logic [NG-1:0] hi_any_next;
    logic [NG-1:0] all_any_next;
    logic [TW-1:0] hi_first_next  [NG];
    logic [TW-1:0] all_first_next [NG];
    logic [NG-1:0] hi_any_reg;
    logic [NG-1:0] all_any_reg;
    logic [TW-1:0] hi_first_reg   [NG];
    logic [TW-1:0] all_first_reg  [NG];
    logic [TW-1:0] pick_hi;
    logic [TW-1:0] pick_all;

    // pointer beyond the queue restarts at tag zero
    assign start_idx = (QS_W'(ptr) < qs) ? ptr : '0;

    // per-group first free tag
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            hi_any_next[g]    = 1'b0;
            all_any_next[g]   = 1'b0;
            hi_first_next[g]  = '0;
            all_first_next[g] = '0;
            for (int k = GW - 1; k >= 0; k--)
            begin
                if ((g * GW + k) < TAG_DEPTH)
                begin
                    if (!used[g * GW + k] && (QS_W'(g * GW + k) < qs))
                    begin
                        all_any_next[g]   = 1'b1;
                        all_first_next[g] = TW'(g * GW + k);
                        if (TW'(g * GW + k) >= start_idx)
                        begin
                            hi_any_next[g]   = 1'b1;
                            hi_first_next[g] = TW'(g * GW + k);
                        end
                    end
                end
            end
        end
    end

    // group summary register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hi_any_reg    <= hi_any_next;
            all_any_reg   <= all_any_next;
            hi_first_reg  <= hi_first_next;
            all_first_reg <= all_first_next;
        end
    end

    // first group wins, wrapped search only when nothing lies at or above the start
    always_comb
    begin
        pick_hi  = '0;
        pick_all = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (hi_any_reg[g])
            begin
                pick_hi = hi_first_reg[g];
            end
            if (all_any_reg[g])
            begin
                pick_all = all_first_reg[g];
            end
        end
    end

    assign found = |all_any_reg;
    assign pick  = (|hi_any_reg) ? pick_hi : pick_all;

endmodule

// ===== hdl/cta_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_check
// Port-level checks of the command tag allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cta_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   req_type,
    input logic                         res_valid,
    input logic                         full_res,
    input logic                         bad_tag,
    input logic [cta_pkg::REM_W-1:0]    desc_remaining,
    input logic                         desc_done
);
    import cta_pkg::*;

    // a result never reports both refusal and unknown tag
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(full_res && bad_tag))
        else $error("full and bad tag flagged together");

    // done only with nothing remaining
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && desc_done) |-> (desc_remaining == '0))
        else $error("done reported with tags remaining");

    // a start request answers in the next cycle with an idle descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_START)) |=> (res_valid && desc_done))
        else $error("start request result missing");

    // the result strobe comes when the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !busy)
        else $error("result while busy");

endmodule

bind command_tag_allocator_core cta_check u_cta_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .res_valid      (res_valid),
    .full_res       (full_res),
    .bad_tag        (bad_tag),
    .desc_remaining (desc_remaining),
    .desc_done      (desc_done)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command tag allocator. Drives allocate, complete
// and start requests under several queue sizes, predicts every result from
// its own model of the tag bitmap and descriptor counts, and compares each
// result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cta_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAG_COUNT   = 256;
    localparam int DESC_COUNT  = 16;

    // one result as seen on the result ports
    typedef struct packed {
        logic [TAG_W-1:0]  tag_out;
        logic              full_res;
        logic              bad_tag;
        logic [DESC_W-1:0] owner_desc;
        logic [REM_W-1:0]  desc_remaining;
        logic [ERR_W-1:0]  desc_status;
        logic              desc_done;
    } tag_result_t;

    // tag bitmap and descriptor accounting, with the queue of predicted results
    class tag_ledger;
        bit          tag_live[TAG_COUNT];
        logic [3:0]  owner_of[TAG_COUNT];
        int          scan_ptr;
        int          live_tags;
        int          desc_live[DESC_COUNT];
        logic [14:0] desc_last_err[DESC_COUNT];
        logic [8:0]  qsize_reg;
        tag_result_t pending_results[$];
        int          fail_count;

        function new();
            qsize_reg  = QS_RESET;
            scan_ptr   = 0;
            live_tags  = 0;
            fail_count = 0;
            foreach (tag_live[i])
            begin
                tag_live[i] = 1'b0;
                owner_of[i] = '0;
            end
            foreach (desc_live[i])
            begin
                desc_live[i]     = 0;
                desc_last_err[i] = '0;
            end
        endfunction

        function void set_queue_size(logic [8:0] v);
            qsize_reg = v;
        endfunction

        // queue size clamped into the legal range
        function int eff_size();
            int s;
            s = qsize_reg;
            if (s < 2)
                s = 2;
            if (s > TAG_COUNT)
                s = TAG_COUNT;
            return s;
        endfunction

        // descriptor fields of a result
        function tag_result_t with_desc(tag_result_t res, int d);
            res.owner_desc     = d[3:0];
            res.desc_remaining = (desc_live[d] > 255) ? 8'hFF : desc_live[d][7:0];
            res.desc_status    = desc_last_err[d];
            res.desc_done      = (desc_live[d] == 0);
            return res;
        endfunction

        function tag_result_t predict_request(req_type_t rt, logic [3:0] d, logic [7:0] t,
                                              logic [14:0] st);
            tag_result_t res;
            int qs;
            int p;
            int o;
            bit found;
            res = '0;
            qs  = eff_size();
            case (rt)
                REQ_ALLOC:
                begin
                    if (live_tags + 1 >= qs)
                        res.full_res = 1'b1;
                    else
                    begin
                        // rotating scan for the first free tag
                        p     = (scan_ptr < qs) ? scan_ptr : 0;
                        found = 1'b0;
                        for (int k = 0; k < qs; k++)
                        begin
                            if (!found)
                            begin
                                if (!tag_live[p])
                                    found = 1'b1;
                                else
                                begin
                                    p++;
                                    if (p >= qs)
                                        p = 0;
                                end
                            end
                        end
                        if (!found)
                            res.full_res = 1'b1;
                        else
                        begin
                            tag_live[p] = 1'b1;
                            owner_of[p] = d;
                            if (desc_live[d] < 511)
                                desc_live[d]++;
                            live_tags++;
                            scan_ptr    = (p + 1 >= qs) ? 0 : p + 1;
                            res.tag_out = p[7:0];
                            res         = with_desc(res, d);
                        end
                    end
                end
                REQ_COMPLETE:
                begin
                    res.tag_out = t;
                    if (!tag_live[t])
                        res.bad_tag = 1'b1;
                    else
                    begin
                        o           = owner_of[t];
                        tag_live[t] = 1'b0;
                        if (live_tags > 0)
                            live_tags--;
                        // count stays at zero after a start cleared it
                        if (desc_live[o] > 0)
                            desc_live[o]--;
                        if (st != 0)
                            desc_last_err[o] = st;
                        scan_ptr = t;
                        res      = with_desc(res, o);
                    end
                end
                REQ_START:
                begin
                    desc_live[d]     = 0;
                    desc_last_err[d] = '0;
                    res              = with_desc(res, d);
                end
                default:
                    ;
            endcase
            return res;
        endfunction

        function void note_request(req_type_t rt, logic [3:0] d, logic [7:0] t,
                                   logic [14:0] st);
            pending_results.push_back(predict_request(rt, d, t, st));
        endfunction

        function void check_field(string name, logic [31:0] expv, logic [31:0] actv);
            if (actv !== expv)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
                fail_count++;
            end
        endfunction

        function void check_response(tag_result_t got);
            tag_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no request outstanding (tag_out %0d)", got.tag_out);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            check_field("tag_out", want.tag_out, got.tag_out);
            check_field("full_res", want.full_res, got.full_res);
            check_field("bad_tag", want.bad_tag, got.bad_tag);
            check_field("owner_desc", want.owner_desc, got.owner_desc);
            check_field("desc_remaining", want.desc_remaining, got.desc_remaining);
            check_field("desc_status", want.desc_status, got.desc_status);
            check_field("desc_done", want.desc_done, got.desc_done);
        endfunction

        // random outstanding tag, -1 when none
        function int pick_live_tag();
            int n;
            int pick;
            n = 0;
            foreach (tag_live[i])
                if (tag_live[i])
                    n++;
            if (n == 0)
                return -1;
            pick = $urandom_range(0, n - 1);
            foreach (tag_live[i])
            begin
                if (tag_live[i])
                begin
                    if (pick == 0)
                        return i;
                    pick--;
                end
            end
            return -1;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          req_type;
    logic [DESC_W-1:0]   desc_id;
    logic [TAG_W-1:0]    tag_in;
    logic [ERR_W-1:0]    status_in;
    logic                res_valid;
    logic [TAG_W-1:0]    tag_out;
    logic                full_res;
    logic                bad_tag;
    logic [DESC_W-1:0]   owner_desc;
    logic [REM_W-1:0]    desc_remaining;
    logic [ERR_W-1:0]    desc_status;
    logic                desc_done;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tag_ledger ledger;
    int        cycle_count = 0;

    command_tag_allocator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .desc_id        (desc_id),
        .tag_in         (tag_in),
        .status_in      (status_in),
        .res_valid      (res_valid),
        .tag_out        (tag_out),
        .full_res       (full_res),
        .bad_tag        (bad_tag),
        .owner_desc     (owner_desc),
        .desc_remaining (desc_remaining),
        .desc_status    (desc_status),
        .desc_done      (desc_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        tag_result_t got;
        if (rst_n === 1'b1 && res_valid === 1'b1 && ledger != null)
        begin
            got.tag_out        = tag_out;
            got.full_res       = full_res;
            got.bad_tag        = bad_tag;
            got.owner_desc     = owner_desc;
            got.desc_remaining = desc_remaining;
            got.desc_status    = desc_status;
            got.desc_done      = desc_done;
            ledger.check_response(got);
        end
    end

    // present one request and hold it until accepted
    task automatic send_request(req_type_t rt, logic [3:0] d, logic [7:0] t, logic [14:0] st);
        @(negedge clk);
        start     = 1'b1;
        req_type  = rt;
        desc_id   = d;
        tag_in    = t;
        status_in = st;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        ledger.note_request(rt, d, t, st);
    endtask

    // hold off until every predicted result has arrived and the block is idle
    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        do
            @(posedge clk);
        while (ledger.pending_results.size() != 0 || busy !== 1'b0);
    endtask

    // random gap on the request side
    task automatic maybe_pause(int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    endtask

    // queue size write, then read back
    task automatic write_queue_size(logic [8:0] v);
        wait_for_results();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_QUEUE_SIZE, 2'b00};
        pwdata  = {23'd0, v};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        ledger.set_queue_size(v);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        ledger.check_field("queue_size", v, prdata[8:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [14:0] rand_status();
        case ($urandom_range(0, 3))
            0, 1:    return 15'd0;
            2:       return 15'($urandom_range(1, 32767));
            default: return $urandom_range(0, 1) ? 15'h7FFF : 15'h0001;
        endcase
    endfunction

    // mixed random traffic, completions mostly on outstanding tags
    task automatic run_random(int count, int alloc_pct, int idle_pct);
        req_type_t   rt;
        logic [3:0]  d;
        logic [7:0]  t;
        logic [14:0] st;
        int          r;
        int          live;
        repeat (count)
        begin
            maybe_pause(idle_pct);
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
            d  = 4'($urandom_range(0, 15));
            t  = 8'($urandom_range(0, 255));
            st = rand_status();
            if ($urandom_range(0, 99) < alloc_pct)
                rt = REQ_ALLOC;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    rt = REQ_COMPLETE;
                else if (r < 92)
                    rt = REQ_START;
                else
                    rt = REQ_NONE;
            end
            if (rt == REQ_COMPLETE)
            begin
                live = ledger.pick_live_tag();
                if (live >= 0 && $urandom_range(0, 9) < 8)
                    t = 8'(live);
            end
            send_request(rt, d, t, st);
        end
    endtask

    // stimulus
    initial
    begin
        ledger    = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = REQ_ALLOC;
        desc_id   = '0;
        tag_in    = '0;
        status_in = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: unknown tag, unused request type, owner and sticky status
        send_request(REQ_COMPLETE, 4'h0, 8'h00, 15'h0000);
        send_request(REQ_NONE, 4'hF, 8'hFF, 15'h7FFF);
        send_request(REQ_ALLOC, 4'h0, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'hF, 8'hFF, 15'h7FFF);
        send_request(REQ_COMPLETE, 4'h0, 8'h01, 15'h7FFF);
        send_request(REQ_ALLOC, 4'hF, 8'h00, 15'h0000);
        // count underflow after a start request
        send_request(REQ_START, 4'hF, 8'h00, 15'h0000);
        send_request(REQ_COMPLETE, 4'h0, 8'h01, 15'h0000);
        send_request(REQ_COMPLETE, 4'h0, 8'hFF, 15'h0001);
        send_request(REQ_ALLOC, 4'h1, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'h2, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'h3, 8'h00, 15'h0000);
        send_request(REQ_COMPLETE, 4'h0, 8'h00, 15'h0001);
        send_request(REQ_COMPLETE, 4'h0, 8'h01, 15'h4000);
        send_request(REQ_COMPLETE, 4'h0, 8'h03, 15'h0000);
        // search pointer beyond a shrunk queue, then queue full
        write_queue_size(9'd3);
        send_request(REQ_ALLOC, 4'h5, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'h5, 8'h00, 15'h0000);
        // size below the minimum
        write_queue_size(9'd0);
        send_request(REQ_ALLOC, 4'h6, 8'h00, 15'h0000);
        send_request(REQ_COMPLETE, 4'h0, 8'h02, 15'h0002);
        send_request(REQ_COMPLETE, 4'h0, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'h6, 8'h00, 15'h0000);
        send_request(REQ_ALLOC, 4'h6, 8'h00, 15'h0000);
        send_request(REQ_START, 4'h0, 8'h00, 15'h0000);

        // random traffic, sender idles often enough to spread gaps
        write_queue_size(9'd8);
        run_random(50, 50, 15);
        write_queue_size(9'd1);
        run_random(30, 45, 15);
        write_queue_size(9'd256);
        run_random(80, 55, 15);

        // retire everything, then fill the whole queue from one descriptor
        write_queue_size(9'd511);
        for (int t = 0; t < TAG_COUNT; t++)
        begin
            if (ledger.tag_live[t])
            begin
                maybe_pause(74);
                send_request(REQ_COMPLETE, 4'($urandom_range(0, 15)), 8'(t), rand_status());
            end
        end
        send_request(REQ_START, 4'hA, 8'($urandom_range(0, 255)), rand_status());
        repeat (TAG_COUNT)
        begin
            maybe_pause(74);
            send_request(REQ_ALLOC, 4'hA, 8'($urandom_range(0, 255)), rand_status());
        end
        run_random(50, 30, 74);
        write_queue_size(9'd37);
        run_random(50, 50, 74);

        // back-to-back requests
        write_queue_size(9'd2);
        run_random(25, 50, 0);
        write_queue_size(9'd200);
        run_random(60, 55, 0);
        write_queue_size(9'($urandom_range(3, 255)));
        run_random(50, 50, 0);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (ledger.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", ledger.pending_results.size());
            ledger.fail_count += ledger.pending_results.size();
        end
        if (ledger.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== command_tag_allocator_core.f =====
hdl/cta_pkg.sv
hdl/cta_desc_table.sv
hdl/cta_scan.sv
hdl/command_tag_allocator_core.sv
hdl/cta_check.sv
bench/tb_top.sv
